// ===== rtl/lltd_pkg.sv =====
// Package for the least-loaded task dispatcher.
// Holds operation codes, register indexes, the node entry layout and the scoring function.
// Depends on nothing; every other file imports it.
package lltd_pkg;

  localparam int NODE_SLOTS_DEFAULT = 16;

  localparam logic [15:0] TIMEOUT_RESET     = 16'd12000;
  localparam logic [3:0]  RETRY_RESET       = 4'd3;
  localparam logic [6:0]  SCORE_TASK_WEIGHT = 7'd100;
  localparam logic [7:0]  TASKS_MAX         = 8'hFF;
  localparam int          SCORE_W           = 15;

  localparam logic [1:0]  TT_HIGH_ACCURACY  = 2'd2;

  localparam logic        CFG_TIMEOUT       = 1'b0;
  localparam logic        CFG_RETRY         = 1'b1;

  typedef enum logic [2:0] {
    OP_REGISTER     = 3'd0,
    OP_HEARTBEAT    = 3'd1,
    OP_DISPATCH     = 3'd2,
    OP_TASK_RESULT  = 3'd3,
    OP_TICK         = 3'd4,
    OP_MARK_OFFLINE = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MODIFY,
    S_SCAN,
    S_FLUSH,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]  models;
    logic [6:0]  cpu;
    logic [7:0]  tasks;
    logic [31:0] last_beat;
  } node_entry_t;

  typedef struct packed {
    logic        found;
    node_entry_t entry;
  } sel_t;

  function automatic logic [SCORE_W-1:0] score_of(input logic [7:0] tasks,
                                                  input logic [6:0] cpu);
    score_of = SCORE_W'(tasks) * SCORE_W'(SCORE_TASK_WEIGHT) + SCORE_W'(cpu);
  endfunction

endpackage

// ===== rtl/lltd_node_mem.sv =====
// Node table memory: one write port and one registered read port; read data follows in the cycle after rd_en.
// A valid bit per entry makes entries that were never written read as zero.
// Depends on lltd_pkg for the entry layout.
module lltd_node_mem #(
  parameter int NODE_SLOTS = lltd_pkg::NODE_SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [$clog2(NODE_SLOTS)-1:0] rd_addr,
  output lltd_pkg::node_entry_t         rd_data,
  output logic                          rd_known,
  input  logic                          wr_en,
  input  logic [$clog2(NODE_SLOTS)-1:0] wr_addr,
  input  lltd_pkg::node_entry_t         wr_data
);
  import lltd_pkg::*;

  node_entry_t            mem [NODE_SLOTS];
  logic [NODE_SLOTS-1:0]  valid;
  node_entry_t            rd_word;
  logic                   rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

  assign rd_data  = rd_hit ? rd_word : '0;
  assign rd_known = rd_hit;

endmodule

// ===== rtl/lltd_select.sv =====
// Running least-load selector fed one node entry per cycle during a dispatch scan.
// Keeps the best eligible node so far; the earlier index wins a tie.
// Depends on lltd_pkg for the entry layout and the scoring function.
module lltd_select #(
  parameter int NODE_SLOTS = lltd_pkg::NODE_SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          sample,
  input  logic                          eligible,
  input  logic [$clog2(NODE_SLOTS)-1:0] addr,
  input  lltd_pkg::node_entry_t         entry,
  output lltd_pkg::sel_t                status,
  output logic [$clog2(NODE_SLOTS)-1:0] best_addr
);
  import lltd_pkg::*;

  logic               found;
  logic [SCORE_W-1:0] lead_score;
  logic [SCORE_W-1:0] score;
  node_entry_t        best_entry;
  logic               take;

  assign score = score_of(entry.tasks, entry.cpu);
  assign take  = sample && eligible && (!found || (score < lead_score));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_addr  <= addr;
      lead_score <= score;
      best_entry <= entry;
    end
  end

  assign status.found = found;
  assign status.entry = best_entry;

endmodule

// ===== rtl/least_loaded_task_dispatcher.sv =====
// Least-loaded task dispatcher: node table in a synchronous memory with a control sequencer.
// Depends on lltd_pkg, lltd_node_mem and lltd_select.
//
// A transaction is accepted when start is high and busy is low. Register, heartbeat,
// task result, mark offline and unknown operations do one memory read, and register,
// heartbeat and task result then one write back. Dispatch and tick scan the node table
// one entry per cycle through the single read port, then go through flush and finish.
// Each transaction gives exactly one result, shown for one cycle with done high; the
// receiver cannot stall it, so it must take the result in that cycle. busy is low again
// in the cycle that shows done. Configuration writes are taken at any edge with cfg_we high.
module least_loaded_task_dispatcher #(
  parameter int NODE_SLOTS = lltd_pkg::NODE_SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [3:0]  node_index,
  input  logic [1:0]  model_mask,
  input  logic [6:0]  cpu_load,
  input  logic [7:0]  task_count,
  input  logic [1:0]  task_kind,
  input  logic [3:0]  retries_in,
  input  logic [31:0] now_ms,
  output logic        done,
  output logic        dispatched,
  output logic [3:0]  chosen_node,
  output logic        model,
  output logic        requeue,
  output logic        task_failed,
  output logic [3:0]  retries_out,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import lltd_pkg::*;

  localparam int              IDX_W     = $clog2(NODE_SLOTS);
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(NODE_SLOTS - 1);

  state_t            state;
  state_t            state_next;
  logic              accept;

  op_t               cmd_op;
  logic [IDX_W-1:0]  cmd_addr;
  logic              cmd_in_table;
  logic [1:0]        cmd_mask;
  logic [6:0]        cmd_cpu;
  logic [7:0]        cmd_tasks;
  logic              cmd_model;
  logic [3:0]        cmd_retries;
  logic [31:0]       cmd_now;

  logic [IDX_W-1:0]  cnt;
  logic              tag_valid;
  logic [IDX_W-1:0]  tag_addr;
  logic [NODE_SLOTS-1:0] online;

  logic [15:0]       timeout_ms;
  logic [3:0]        retry_limit;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  node_entry_t       rd_data;
  logic              rd_known;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  node_entry_t       wr_data;

  sel_t              sel;
  logic [IDX_W-1:0]  sel_addr;
  logic              sel_sample;
  logic              sel_eligible;
  logic              expired;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  lltd_node_mem #(.NODE_SLOTS(NODE_SLOTS)) u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .rd_known (rd_known),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  assign sel_sample   = tag_valid && (cmd_op == OP_DISPATCH);
  assign sel_eligible = online[tag_addr] && rd_data.models[cmd_model];

  lltd_select #(.NODE_SLOTS(NODE_SLOTS)) u_select (
    .clk       (clk),
    .rst       (rst),
    .clear     (accept),
    .sample    (sel_sample),
    .eligible  (sel_eligible),
    .addr      (tag_addr),
    .entry     (rd_data),
    .status    (sel),
    .best_addr (sel_addr)
  );

  assign expired = (cmd_now - rd_data.last_beat) > {16'd0, timeout_ms};

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if ((op_t'(op) == OP_DISPATCH) || (op_t'(op) == OP_TICK)) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_MODIFY;
          end
        end
      end
      S_MODIFY: state_next = S_IDLE;
      S_SCAN: begin
        if (cnt == LAST_ADDR) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH:  state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt;
    wr_en   = 1'b0;
    wr_addr = cmd_addr;
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        rd_en   = start;
        rd_addr = IDX_W'(node_index);
      end
      S_SCAN: begin
        rd_en = 1'b1;
      end
      S_MODIFY: begin
        unique case (cmd_op)
          OP_REGISTER: begin
            wr_en             = cmd_in_table;
            wr_data.models    = cmd_mask;
            wr_data.cpu       = '0;
            wr_data.tasks     = '0;
            wr_data.last_beat = cmd_now;
          end
          OP_HEARTBEAT: begin
            wr_en             = cmd_in_table && rd_known;
            wr_data.cpu       = cmd_cpu;
            wr_data.tasks     = cmd_tasks;
            wr_data.last_beat = cmd_now;
          end
          OP_TASK_RESULT: begin
            wr_en         = cmd_in_table && rd_known && (rd_data.tasks != 8'd0);
            wr_data.tasks = rd_data.tasks - 8'd1;
          end
          default: begin
            wr_en = 1'b0;
          end
        endcase
      end
      S_FINISH: begin
        wr_en   = (cmd_op == OP_DISPATCH) && sel.found;
        wr_addr = sel_addr;
        wr_data = sel.entry;
        if (sel.entry.tasks != TASKS_MAX) begin
          wr_data.tasks = sel.entry.tasks + 8'd1;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      tag_valid   <= 1'b0;
      online      <= '0;
      timeout_ms  <= TIMEOUT_RESET;
      retry_limit <= RETRY_RESET;
      done        <= 1'b0;
    end else begin
      state     <= state_next;
      tag_valid <= (state == S_SCAN);
      done      <= (state == S_MODIFY) || (state == S_FINISH);

      if (accept) begin
        cnt <= '0;
      end else if (state == S_SCAN) begin
        cnt <= cnt + 1'b1;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TIMEOUT: timeout_ms  <= cfg_data;
          CFG_RETRY:   retry_limit <= cfg_data[3:0];
        endcase
      end

      if (state == S_MODIFY && cmd_in_table) begin
        if (cmd_op == OP_REGISTER) begin
          online[cmd_addr] <= 1'b1;
        end else if (cmd_op == OP_HEARTBEAT && rd_known) begin
          online[cmd_addr] <= 1'b1;
        end else if (cmd_op == OP_MARK_OFFLINE && rd_known) begin
          online[cmd_addr] <= 1'b0;
        end
      end
      if (tag_valid && cmd_op == OP_TICK && expired) begin
        online[tag_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_addr <= cnt;
    if (accept) begin
      cmd_op       <= op_t'(op);
      cmd_addr     <= IDX_W'(node_index);
      cmd_in_table <= (32'(node_index) < NODE_SLOTS);
      cmd_mask     <= model_mask;
      cmd_cpu      <= cpu_load;
      cmd_tasks    <= task_count;
      cmd_model    <= (task_kind == TT_HIGH_ACCURACY);
      cmd_retries  <= retries_in;
      cmd_now      <= now_ms;
    end

    dispatched  <= 1'b0;
    chosen_node <= '0;
    model       <= 1'b0;
    requeue     <= 1'b0;
    task_failed <= 1'b0;
    retries_out <= '0;
    if (state == S_FINISH && cmd_op == OP_DISPATCH) begin
      model <= cmd_model;
      if (sel.found) begin
        dispatched  <= 1'b1;
        chosen_node <= 4'(sel_addr);
      end else if (cmd_retries < retry_limit) begin
        requeue     <= 1'b1;
        retries_out <= cmd_retries + 4'd1;
      end else begin
        task_failed <= 1'b1;
      end
    end
  end

endmodule
